FILE: rtl/srp_pkg.sv
// Shared types and constants of the stream pattern replacer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

   // Largest pattern length the window can hold
   localparam int MAX_PATTERN_DEFAULT = 8;

   // Replacement store and job payload size
   localparam int REPL_BYTES = 8;
   localparam int JOB_W      = 8 * REPL_BYTES;
   localparam int JOB_CNT_W  = 4;

   // Depth of the job queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

   // Input transaction
   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_final;
   } srp_req_type;

   // Result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       text_done;
   } srp_rsp_type;

   // Configuration registers as seen by the front
   typedef struct packed {
      logic [63:0] pattern_bytes;
      logic [3:0]  pattern_length;
      logic [63:0] replacement_bytes;
      logic [3:0]  replacement_length;
   } srp_cfg_type;

   // One job: the results caused by one input transaction
   typedef struct packed {
      logic [JOB_W-1:0]     bytes;     // byte i in bits 8i+7..8i
      logic [JOB_CNT_W-1:0] count;     // number of text bytes, 0 means bare end mark
      logic                 is_final;  // last byte closes the text
   } srp_job_type;

endpackage

`default_nettype wire

FILE: rtl/srp_csr.sv
// Configuration register file of the stream pattern replacer.
// Depends on srp_pkg for the register indexes and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module srp_csr
   import srp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output srp_cfg_type                cfg
);

   srp_cfg_type cfg_ff, cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_BYTES:      cfg_in.pattern_bytes      = csr_wdata;
            CSR_PATTERN_LENGTH:     cfg_in.pattern_length     = csr_wdata[3:0];
            CSR_REPLACEMENT_BYTES:  cfg_in.replacement_bytes  = csr_wdata;
            CSR_REPLACEMENT_LENGTH: cfg_in.replacement_length = csr_wdata[3:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes      <= '0;
         cfg_ff.pattern_length     <= 4'd1;
         cfg_ff.replacement_bytes  <= '0;
         cfg_ff.replacement_length <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/srp_front.sv
// Front end: accepts text bytes, keeps the window of unemitted bytes,
// compares it with the pattern and turns each transaction into one job.
// Depends on srp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srp_front
   import srp_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire srp_cfg_type cfg,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire srp_req_type req_data,
   input  wire logic        queue_full,
   output logic             job_push,
   output srp_job_type      job
);

   localparam int WIN_W = 8 * MAX_PATTERN;
   localparam int CW    = $clog2(MAX_PATTERN + 1);

   logic [WIN_W-1:0] win_ff, win_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   logic             accept;
   logic [WIN_W-1:0] app_win;
   logic [3:0]       app_cnt;
   logic [3:0]       eff_p;
   logic [3:0]       eff_r;
   logic             shrink;
   logic             at_len;
   logic             match;
   logic             hit;
   logic [1:0]       shift_n;
   logic [3:0]       left_cnt;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Clamp the configured lengths
   always_comb begin
      eff_p = cfg.pattern_length;
      if (eff_p == 4'd0) begin
         eff_p = 4'd1;
      end else if (eff_p > 4'(MAX_PATTERN)) begin
         eff_p = 4'(MAX_PATTERN);
      end
      eff_r = (cfg.replacement_length > 4'(REPL_BYTES)) ?
              4'(REPL_BYTES) : cfg.replacement_length;
   end

   // Append the new byte behind the pending ones
   always_comb begin
      app_win = win_ff;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (CW'(i) == cnt_ff) begin
            app_win[8*i +: 8] = req_data.text_byte;
         end
      end
      app_cnt = 4'(cnt_ff) + 4'd1;
   end

   // Classify: window over length, at length (match or not), or short
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((4'(i) < eff_p) && (app_win[8*i +: 8] != cfg.pattern_bytes[8*i +: 8])) begin
            match = 1'b0;
         end
      end
      shrink = app_cnt > eff_p;
      at_len = app_cnt == eff_p;
      hit    = at_len && match;
   end

   // Bytes leaving the window on a non-final transaction
   always_comb begin
      if (shrink) begin
         shift_n = 2'd2;
      end else if (at_len && !hit) begin
         shift_n = 2'd1;
      end else begin
         shift_n = 2'd0;
      end
      left_cnt = hit ? 4'd0 : (app_cnt - 4'(shift_n));
   end

   // Build the job and the next window
   always_comb begin
      job.bytes    = hit ? cfg.replacement_bytes : JOB_W'(app_win);
      job.is_final = req_data.is_final;
      if (req_data.is_final) begin
         job.count = hit ? eff_r : app_cnt;
      end else if (hit) begin
         job.count = eff_r;
      end else begin
         job.count = 4'(shift_n);
      end
      job_push = accept && (req_data.is_final || (job.count != '0));

      win_in = app_win >> {shift_n, 3'b000};
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = req_data.is_final ? '0 : CW'(left_cnt);
      end
   end

   // Window bytes carry no reset, only the fill count does
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/srp_queue.sv
// Short job queue that decouples the front from the back.
// Depends on srp_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module srp_queue
   import srp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire srp_job_type push_job,
   output logic             full,
   input  wire logic        pop,
   output logic             head_valid,
   output srp_job_type      head_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   srp_job_type    mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]  num_ff, num_in;
   logic           do_push;
   logic           do_pop;

   assign full       = num_ff == NW'(DEPTH);
   assign head_valid = num_ff != '0;
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      num_in = num_ff + NW'(do_push) - NW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         num_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         num_ff    <= num_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/srp_back.sv
// Back end: walks the head job one result per cycle unless the output
// stalls, drives the registered result channel. Depends on srp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srp_back
   import srp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        head_valid,
   input  wire srp_job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output srp_rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(REPL_BYTES);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   srp_rsp_type      rsp_data_ff, rsp_data_in;
   logic             out_free;
   logic             last_one;
   logic             bare;

   // Output slot can take a new result when empty or being taken now
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign bare     = head_job.count == '0;
   assign last_one = bare || ((JOB_CNT_W'(idx_ff) + JOB_CNT_W'(1)) == head_job.count);
   assign pop      = out_free && head_valid && last_one;

   // Form the next result from the head job
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      if (out_free) begin
         rsp_valid_in = head_valid;
         if (bare) begin
            rsp_data_in.out_byte   = 8'd0;
            rsp_data_in.byte_valid = 1'b0;
         end else begin
            rsp_data_in.out_byte   = head_job.bytes[{idx_ff, 3'b000} +: 8];
            rsp_data_in.byte_valid = 1'b1;
         end
         rsp_data_in.run_last  = last_one;
         rsp_data_in.text_done = last_one && head_job.is_final;
         if (head_valid) begin
            idx_in = last_one ? '0 : idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/stream_pattern_replacer.sv
// Top level of the stream pattern replacer: config registers, front, job queue, back.
// Depends on srp_pkg, srp_csr, srp_front, srp_queue and srp_back.
`timescale 1ns / 1ps
`default_nettype none

// Streaming find-and-replace, one text byte per input transaction. Every
// leftmost, non-overlapping occurrence of the configured pattern is replaced
// by the replacement; all other bytes pass in order. The front takes one byte
// per cycle unless the queue is full, turning it into a job of zero to eight
// results; a two-entry job queue feeds the back, which sends one result per
// cycle unless the output stalls, through a registered output. An input
// transaction that causes at most one result thus sustains one transaction
// per cycle unless the output stalls; one that causes more results holds the
// output for each in turn, and the input stalls once the queue is full. The
// first result of a transaction is registered in the job queue, then in the
// output register. Write the configuration only while the block is idle.
module stream_pattern_replacer
   import srp_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire srp_req_type           req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output srp_rsp_type                rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   srp_cfg_type cfg;
   srp_job_type push_job;
   srp_job_type head_job;
   logic        job_push;
   logic        queue_full;
   logic        head_valid;
   logic        job_pop;

   srp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   srp_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job        (push_job)
   );

   srp_queue #(
      .DEPTH (QUEUE_DEPTH_DEFAULT)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   srp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (job_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/srp_checker.sv
// Port-level checks of the stream pattern replacer, bound to the top level.
// Depends on srp_pkg and stream_pattern_replacer.
`timescale 1ns / 1ps
`default_nettype none

module srp_checker
   import srp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire srp_req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire srp_rsp_type rsp_data
);

   // A stalled input transaction holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("input changed while stalled");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A bare end mark closes the run and the text and carries a zero byte
   a_bare_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |->
         rsp_data.run_last && rsp_data.text_done && (rsp_data.out_byte == 8'd0))
      else $error("bare end mark malformed");

   // The end of the text is always the end of a run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.text_done |-> rsp_data.run_last)
      else $error("text end without run end");

   // Reset empties the result channel
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stream_pattern_replacer srp_checker u_srp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
